FILE: src/dbd_pkg.sv
// ----------------------------------------------------------------------------
// dbd_pkg
// Shared types and constants for the detection box decode block.
// ----------------------------------------------------------------------------
package dbd_pkg;

    // Default parameter values
    localparam int MAX_CLASSES_DEF   = 128;
    localparam int FRACTION_BITS_DEF = 15;

    // Field widths
    localparam int SCORE_W   = 16;
    localparam int BOX_W     = 17;
    localparam int SIZE_W    = 13;
    localparam int COUNT_W   = 8;
    localparam int TAG_W     = 8;
    localparam int LO_PX_W   = 13;
    localparam int HI_PX_W   = 14;

    // Sums of 2*center +/- size, and their products with the image size
    localparam int SUM_W     = BOX_W + 2;
    localparam int PROD_W    = SUM_W + SIZE_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_WIDTH     = 2'd1,
        CFG_HEIGHT    = 2'd2,
        CFG_COUNT     = 2'd3
    } cfg_index_t;

    // Register reset values
    localparam logic [SCORE_W-1:0] THRESHOLD_RST = 16'd7864;
    localparam logic [SIZE_W-1:0]  WIDTH_RST     = 13'd640;
    localparam logic [SIZE_W-1:0]  HEIGHT_RST    = 13'd480;
    localparam logic [COUNT_W-1:0] COUNT_RST     = 8'd80;

endpackage

FILE: src/dbd_axis.sv
// ----------------------------------------------------------------------------
// dbd_axis
// Scale one axis to pixels: truncate both edge products toward zero and
// clamp the low edge at zero, the high edge at size minus one; saturate both.
// ----------------------------------------------------------------------------
module dbd_axis
    import dbd_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic signed [PROD_W-1:0]  prod_lo,
    input  logic signed [PROD_W-1:0]  prod_hi,
    input  logic        [SIZE_W-1:0]  size,
    output logic        [LO_PX_W-1:0] lo_px,
    output logic signed [HI_PX_W-1:0] hi_px
);

    localparam int SHIFT = FRACTION_BITS + 1;
    localparam logic signed [PROD_W-1:0] BIAS = PROD_W'((1 << SHIFT) - 1);
    localparam logic signed [PROD_W-1:0] LO_MAX = PROD_W'((1 << LO_PX_W) - 1);
    localparam logic signed [PROD_W-1:0] HI_MIN = -PROD_W'(1 << (HI_PX_W - 1));

    logic signed [PROD_W-1:0] q_lo;
    logic signed [PROD_W-1:0] q_hi;
    logic signed [PROD_W-1:0] hi_lim;
    logic signed [PROD_W-1:0] hi_cl;

    // Arithmetic shift rounds down; bias negative values to round toward zero
    assign q_lo = (prod_lo < 0) ? ((prod_lo + BIAS) >>> SHIFT) : (prod_lo >>> SHIFT);
    assign q_hi = (prod_hi < 0) ? ((prod_hi + BIAS) >>> SHIFT) : (prod_hi >>> SHIFT);

    assign hi_lim = $signed({{(PROD_W - SIZE_W){1'b0}}, size}) - PROD_W'(1);

    always_comb
    begin
        if (q_lo < 0)
        begin
            lo_px = '0;
        end
        else if (q_lo > LO_MAX)
        begin
            lo_px = LO_MAX[LO_PX_W-1:0];
        end
        else
        begin
            lo_px = q_lo[LO_PX_W-1:0];
        end
    end

    always_comb
    begin
        hi_cl = (q_hi > hi_lim) ? hi_lim : q_hi;
        if (hi_cl < HI_MIN)
        begin
            hi_cl = HI_MIN;
        end
        hi_px = hi_cl[HI_PX_W-1:0];
    end

endmodule

FILE: src/detection_box_decode.sv
// ----------------------------------------------------------------------------
// detection_box_decode
// Argmax over a detection's class scores, confidence test and pixel box.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests carry one class score each, class_count of them per
//   detection in class order. A request is taken at a clock edge with
//   in_valid high and in_stall low. The box fields, last_detection and
//   frame_tag are sampled from the final class request of each detection.
//   Each detection yields exactly one output request, taken at an edge with
//   out_valid high and out_stall low. Box fields read zero when not kept.
//   Throughput: one score request per cycle while in_stall is low. The
//   argmax is a single compare-and-update per request; the box path is three
//   register stages (capture, 19x14 multiply, round and clamp), each advancing
//   one step per cycle when the stage after it can take the result.
//   Result path: the final class request is registered in the capture stage,
//   then the multiply stage, then the output register, which drives out_valid.
//   Stall: when out_stall holds a result, the box pipeline fills and
//   in_stall rises only once the capture stage is full.
//   Configuration: cfg_ready is always high; write only while idle.
//   Reset: registers return to 7864 / 640 / 480 / 80, the argmax and class
//   position clear and the pipeline empties.
// ----------------------------------------------------------------------------
module detection_box_decode
    import dbd_pkg::*;
#(
    parameter int MAX_CLASSES   = MAX_CLASSES_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int IDX_W        = $clog2(MAX_CLASSES)
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    // Configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,

    // Score input channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [SCORE_W-1:0]        class_score,
    input  logic signed [BOX_W-1:0]   center_x,
    input  logic signed [BOX_W-1:0]   center_y,
    input  logic signed [BOX_W-1:0]   box_width,
    input  logic signed [BOX_W-1:0]   box_height,
    input  logic                      last_detection,
    input  logic [TAG_W-1:0]          frame_tag,

    // Result channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      kept,
    output logic [IDX_W-1:0]          best_class,
    output logic [SCORE_W-1:0]        confidence,
    output logic [LO_PX_W-1:0]        left_px,
    output logic [LO_PX_W-1:0]        top_px,
    output logic signed [HI_PX_W-1:0] right_px,
    output logic signed [HI_PX_W-1:0] bottom_px,
    output logic                      frame_end,
    output logic [TAG_W-1:0]          result_tag
);

    localparam int CNT_W = (IDX_W + 1 > COUNT_W) ? IDX_W + 1 : COUNT_W;
    localparam logic [31:0] SCORE_ONE = 32'(1) << FRACTION_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SCORE_W-1:0] score_threshold_reg;
    logic [SIZE_W-1:0]  image_width_reg;
    logic [SIZE_W-1:0]  image_height_reg;
    logic [COUNT_W-1:0] class_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_threshold_reg <= THRESHOLD_RST;
            image_width_reg     <= WIDTH_RST;
            image_height_reg    <= HEIGHT_RST;
            class_count_reg     <= COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_THRESHOLD: score_threshold_reg <= cfg_data;
                CFG_WIDTH:     image_width_reg     <= cfg_data[SIZE_W-1:0];
                CFG_HEIGHT:    image_height_reg    <= cfg_data[SIZE_W-1:0];
                CFG_COUNT:     class_count_reg     <= cfg_data[COUNT_W-1:0];
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage advances when it is empty or the
    // stage after it advances.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic ready_out;
    logic ready_s2;
    logic ready_s1;
    logic in_accept;

    assign ready_out = !out_valid_reg || !out_stall;
    assign ready_s2  = !s2_valid_reg || ready_out;
    assign ready_s1  = !s1_valid_reg || ready_s2;
    assign in_stall  = !ready_s1;
    assign in_accept = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Running argmax
    // ------------------------------------------------------------------
    logic [SCORE_W-1:0] best_score_reg;
    logic [IDX_W-1:0]   best_index_reg;
    logic [IDX_W-1:0]   class_position_reg;

    logic [CNT_W-1:0]   count_ext;
    logic [CNT_W-1:0]   count_eff;
    logic [CNT_W-1:0]   pos_plus1;
    logic               is_final;
    logic               take_new;
    logic [SCORE_W-1:0] sel_score;
    logic [IDX_W-1:0]   sel_index;
    logic               kept_in;

    // Clip the class count into one .. MAX_CLASSES
    assign count_ext = CNT_W'(class_count_reg);
    assign count_eff = (count_ext == '0) ? CNT_W'(1) :
                       (count_ext > CNT_W'(MAX_CLASSES)) ? CNT_W'(MAX_CLASSES) : count_ext;
    assign pos_plus1 = CNT_W'(class_position_reg) + CNT_W'(1);
    assign is_final  = (pos_plus1 >= count_eff);

    // First class always takes over; later ones only on a strict win
    assign take_new  = (class_position_reg == '0) || (class_score > best_score_reg);
    assign sel_score = take_new ? class_score : best_score_reg;
    assign sel_index = take_new ? class_position_reg : best_index_reg;

    assign kept_in = (32'(sel_score) <= SCORE_ONE) && (sel_score > score_threshold_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_score_reg     <= '0;
            best_index_reg     <= '0;
            class_position_reg <= '0;
        end
        else if (in_accept)
        begin
            if (is_final)
            begin
                best_score_reg     <= '0;
                best_index_reg     <= '0;
                class_position_reg <= '0;
            end
            else
            begin
                best_score_reg     <= sel_score;
                best_index_reg     <= sel_index;
                class_position_reg <= class_position_reg + IDX_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the final class request, form 2*center -/+ size
    // ------------------------------------------------------------------
    logic                     s1_kept_reg;
    logic [IDX_W-1:0]         s1_class_reg;
    logic [SCORE_W-1:0]       s1_conf_reg;
    logic                     s1_end_reg;
    logic [TAG_W-1:0]         s1_tag_reg;
    logic signed [SUM_W-1:0]  s1_xlo_reg;
    logic signed [SUM_W-1:0]  s1_xhi_reg;
    logic signed [SUM_W-1:0]  s1_ylo_reg;
    logic signed [SUM_W-1:0]  s1_yhi_reg;

    logic signed [SUM_W-1:0]  cx2;
    logic signed [SUM_W-1:0]  cy2;
    logic signed [SUM_W-1:0]  bw_ext;
    logic signed [SUM_W-1:0]  bh_ext;

    assign cx2    = $signed({center_x[BOX_W-1], center_x, 1'b0});
    assign cy2    = $signed({center_y[BOX_W-1], center_y, 1'b0});
    assign bw_ext = $signed({{2{box_width[BOX_W-1]}}, box_width});
    assign bh_ext = $signed({{2{box_height[BOX_W-1]}}, box_height});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (ready_s1)
        begin
            s1_valid_reg <= in_accept && is_final;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && is_final)
        begin
            s1_kept_reg  <= kept_in;
            s1_class_reg <= sel_index;
            s1_conf_reg  <= sel_score;
            s1_end_reg   <= last_detection;
            s1_tag_reg   <= frame_tag;
            s1_xlo_reg   <= cx2 - bw_ext;
            s1_xhi_reg   <= cx2 + bw_ext;
            s1_ylo_reg   <= cy2 - bh_ext;
            s1_yhi_reg   <= cy2 + bh_ext;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: scale by image size
    // ------------------------------------------------------------------
    logic                     s2_kept_reg;
    logic [IDX_W-1:0]         s2_class_reg;
    logic [SCORE_W-1:0]       s2_conf_reg;
    logic                     s2_end_reg;
    logic [TAG_W-1:0]         s2_tag_reg;
    logic signed [PROD_W-1:0] s2_xlo_reg;
    logic signed [PROD_W-1:0] s2_xhi_reg;
    logic signed [PROD_W-1:0] s2_ylo_reg;
    logic signed [PROD_W-1:0] s2_yhi_reg;

    logic signed [PROD_W-1:0] w_ext;
    logic signed [PROD_W-1:0] h_ext;

    assign w_ext = $signed({{(PROD_W - SIZE_W){1'b0}}, image_width_reg});
    assign h_ext = $signed({{(PROD_W - SIZE_W){1'b0}}, image_height_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (ready_s2)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && ready_s2)
        begin
            s2_kept_reg  <= s1_kept_reg;
            s2_class_reg <= s1_class_reg;
            s2_conf_reg  <= s1_conf_reg;
            s2_end_reg   <= s1_end_reg;
            s2_tag_reg   <= s1_tag_reg;
            s2_xlo_reg   <= PROD_W'(s1_xlo_reg) * w_ext;
            s2_xhi_reg   <= PROD_W'(s1_xhi_reg) * w_ext;
            s2_ylo_reg   <= PROD_W'(s1_ylo_reg) * h_ext;
            s2_yhi_reg   <= PROD_W'(s1_yhi_reg) * h_ext;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: truncate, clamp and hold the result until taken
    // ------------------------------------------------------------------
    logic [LO_PX_W-1:0]        x_lo_px;
    logic signed [HI_PX_W-1:0] x_hi_px;
    logic [LO_PX_W-1:0]        y_lo_px;
    logic signed [HI_PX_W-1:0] y_hi_px;

    dbd_axis #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_axis_x (
        .prod_lo (s2_xlo_reg),
        .prod_hi (s2_xhi_reg),
        .size    (image_width_reg),
        .lo_px   (x_lo_px),
        .hi_px   (x_hi_px)
    );

    dbd_axis #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_axis_y (
        .prod_lo (s2_ylo_reg),
        .prod_hi (s2_yhi_reg),
        .size    (image_height_reg),
        .lo_px   (y_lo_px),
        .hi_px   (y_hi_px)
    );

    logic                      kept_reg;
    logic [IDX_W-1:0]          best_class_reg;
    logic [SCORE_W-1:0]        confidence_reg;
    logic [LO_PX_W-1:0]        left_px_reg;
    logic [LO_PX_W-1:0]        top_px_reg;
    logic signed [HI_PX_W-1:0] right_px_reg;
    logic signed [HI_PX_W-1:0] bottom_px_reg;
    logic                      frame_end_reg;
    logic [TAG_W-1:0]          result_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ready_out)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && ready_out)
        begin
            kept_reg       <= s2_kept_reg;
            best_class_reg <= s2_class_reg;
            confidence_reg <= s2_conf_reg;
            frame_end_reg  <= s2_end_reg;
            result_tag_reg <= s2_tag_reg;
            // Drop the box of a rejected detection
            left_px_reg    <= s2_kept_reg ? x_lo_px : '0;
            right_px_reg   <= s2_kept_reg ? x_hi_px : '0;
            top_px_reg     <= s2_kept_reg ? y_lo_px : '0;
            bottom_px_reg  <= s2_kept_reg ? y_hi_px : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kept       = kept_reg;
    assign best_class = best_class_reg;
    assign confidence = confidence_reg;
    assign left_px    = left_px_reg;
    assign top_px     = top_px_reg;
    assign right_px   = right_px_reg;
    assign bottom_px  = bottom_px_reg;
    assign frame_end  = frame_end_reg;
    assign result_tag = result_tag_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Input backs up only when the capture stage is occupied
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("in_stall raised with an empty capture stage");

    // A blocked stage 2 result is not lost
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !ready_out) |=> s2_valid_reg)
        else $error("stage 2 result dropped while blocked");

    // A rejected detection carries an all-zero box
    a_reject_zero_box: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !kept) |-> (left_px == '0 && top_px == '0 &&
                                  right_px == '0 && bottom_px == '0))
        else $error("rejected detection with a nonzero box");

    // A kept detection never scores above 1.0
    a_kept_score: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kept) |-> (32'(confidence) <= SCORE_ONE))
        else $error("kept detection with score above 1.0");

endmodule

FILE: dv/detection_box_decode_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// detection_box_decode_test
// Self-checking bench for the detection box decode block. A queue of class
// score requests feeds a bursty driver, a stalling monitor checks each result
// against a predicted box (argmax, confidence test, pixel edges with clamps),
// and the configuration is changed between quiet phases.
// ----------------------------------------------------------------------------
module detection_box_decode_test;
    import dbd_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 12;
    localparam int REPORT_MAX    = 10;
    localparam int CLS_W         = $clog2(MAX_CLASSES_DEF);
    localparam longint LO_PX_MAX = (longint'(1) << LO_PX_W) - 1;
    localparam longint HI_PX_MIN = -(longint'(1) << (HI_PX_W - 1));

    // One score request as it sits on the input channel
    typedef struct packed {
        logic [SCORE_W-1:0]      score;
        logic signed [BOX_W-1:0] cx;
        logic signed [BOX_W-1:0] cy;
        logic signed [BOX_W-1:0] bw;
        logic signed [BOX_W-1:0] bh;
        logic                    last;
        logic [TAG_W-1:0]        tag;
    } score_req_t;

    // One decoded detection as it leaves the result channel
    typedef struct packed {
        logic                        kept;
        logic [CLS_W-1:0]            cls;
        logic [SCORE_W-1:0]          conf;
        logic [LO_PX_W-1:0]          left;
        logic [LO_PX_W-1:0]          top;
        logic signed [HI_PX_W-1:0]   right;
        logic signed [HI_PX_W-1:0]   bottom;
        logic                        fend;
        logic [TAG_W-1:0]            tag;
    } box_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    cfg_index_t                cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic [SCORE_W-1:0]        class_score;
    logic signed [BOX_W-1:0]   center_x;
    logic signed [BOX_W-1:0]   center_y;
    logic signed [BOX_W-1:0]   box_width;
    logic signed [BOX_W-1:0]   box_height;
    logic                      last_detection;
    logic [TAG_W-1:0]          frame_tag;
    logic                      out_valid;
    logic                      out_stall;
    logic                      kept;
    logic [CLS_W-1:0]          best_class;
    logic [SCORE_W-1:0]        confidence;
    logic [LO_PX_W-1:0]        left_px;
    logic [LO_PX_W-1:0]        top_px;
    logic signed [HI_PX_W-1:0] right_px;
    logic signed [HI_PX_W-1:0] bottom_px;
    logic                      frame_end;
    logic [TAG_W-1:0]          result_tag;

    // Stimulus and expectation stores
    score_req_t  score_requests[$];
    box_result_t expected_boxes[$];
    score_req_t  cur_req;
    bit          score_taken;
    int          scores_queued;
    int          scores_taken;
    int          mismatches;
    int          cycle_count;

    // Predicted configuration and argmax state
    logic [SCORE_W-1:0] score_thr;
    logic [SIZE_W-1:0]  img_w;
    logic [SIZE_W-1:0]  img_h;
    logic [COUNT_W-1:0] cls_count;
    logic [SCORE_W-1:0] run_best;
    logic [CLS_W-1:0]   run_class;
    int                 class_pos;

    // Sender burst and receiver stall pattern state
    int burst_left;
    int gap_left;
    int stall_tick;
    int stall_style;

    detection_box_decode DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .class_score    (class_score),
        .center_x       (center_x),
        .center_y       (center_y),
        .box_width      (box_width),
        .box_height     (box_height),
        .last_detection (last_detection),
        .frame_tag      (frame_tag),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kept           (kept),
        .best_class     (best_class),
        .confidence     (confidence),
        .left_px        (left_px),
        .top_px         (top_px),
        .right_px       (right_px),
        .bottom_px      (bottom_px),
        .frame_end      (frame_end),
        .result_tag     (result_tag)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Map the class count register onto the number of scores per detection:
    // zero acts as one, anything above the class limit acts as the limit.
    function automatic int effective_count(logic [COUNT_W-1:0] cnt);
        if (cnt == 0)
            return 1;
        if (cnt > MAX_CLASSES_DEF)
            return MAX_CLASSES_DEF;
        return cnt;
    endfunction

    // Pixel edge trunc((c +/- s/2) * size) with c and s in fixed point.
    // Signed integer division truncates toward zero.
    function automatic longint px_edge(longint c, longint s, longint sgn, longint size);
        return ((2 * c + sgn * s) * size) / (longint'(2) << FRACTION_BITS_DEF);
    endfunction

    // Fold one accepted score into the running argmax; on the final class
    // build the expected result and clear the argmax for the next detection.
    task automatic absorb_score(input score_req_t r);
        box_result_t res;
        longint      left, top, right, bottom;
        if (class_pos == 0 || r.score > run_best)
        begin
            run_best  = r.score;
            run_class = CLS_W'(class_pos);
        end
        if (class_pos + 1 < effective_count(cls_count))
        begin
            class_pos++;
        end
        else
        begin
            res = '0;
            res.kept = (int'(run_best) <= (1 << FRACTION_BITS_DEF)) && (run_best > score_thr);
            if (res.kept)
            begin
                left   = px_edge($signed(r.cx), $signed(r.bw), -1, longint'(img_w));
                right  = px_edge($signed(r.cx), $signed(r.bw), 1, longint'(img_w));
                top    = px_edge($signed(r.cy), $signed(r.bh), -1, longint'(img_h));
                bottom = px_edge($signed(r.cy), $signed(r.bh), 1, longint'(img_h));
                // One-sided clamps first, then saturate to the port widths
                if (left < 0)
                    left = 0;
                if (top < 0)
                    top = 0;
                if (right > longint'(img_w) - 1)
                    right = longint'(img_w) - 1;
                if (bottom > longint'(img_h) - 1)
                    bottom = longint'(img_h) - 1;
                if (left > LO_PX_MAX)
                    left = LO_PX_MAX;
                if (top > LO_PX_MAX)
                    top = LO_PX_MAX;
                if (right < HI_PX_MIN)
                    right = HI_PX_MIN;
                if (bottom < HI_PX_MIN)
                    bottom = HI_PX_MIN;
                res.left   = LO_PX_W'(left);
                res.top    = LO_PX_W'(top);
                res.right  = HI_PX_W'(right);
                res.bottom = HI_PX_W'(bottom);
            end
            res.cls  = run_class;
            res.conf = run_best;
            res.fend = r.last;
            res.tag  = r.tag;
            expected_boxes = {expected_boxes, res};
            run_best  = '0;
            run_class = '0;
            class_pos = 0;
        end
    endtask

    // Write one register through the configuration channel and mirror it
    task automatic write_reg(input cfg_index_t idx, input int val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_THRESHOLD: score_thr = SCORE_W'(val);
            CFG_WIDTH:     img_w     = SIZE_W'(val);
            CFG_HEIGHT:    img_h     = SIZE_W'(val);
            CFG_COUNT:     cls_count = COUNT_W'(val);
            default:       ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input int thr, input int w, input int h, input int cnt);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_COUNT, cnt);
    endtask

    task automatic queue_req(input logic [SCORE_W-1:0] score,
                             input logic signed [BOX_W-1:0] cx, input logic signed [BOX_W-1:0] cy,
                             input logic signed [BOX_W-1:0] bw, input logic signed [BOX_W-1:0] bh,
                             input logic last, input logic [TAG_W-1:0] tag);
        score_req_t req;
        req = '{score, cx, cy, bw, bh, last, tag};
        score_requests = {score_requests, req};
        scores_queued++;
    endtask

    // Hold until every request is taken and every result is back, then let
    // the pipeline run empty before anything touches the registers.
    task automatic wait_quiet();
        do @(negedge clk); while (scores_taken != scores_queued || expected_boxes.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Box coordinate: mostly a sane fraction, sometimes the full field range
    function automatic logic signed [BOX_W-1:0] pick_coord();
        case ($urandom_range(0, 19))
            0, 1, 2: return BOX_W'($urandom);
            3:       return BOX_W'(-65536);
            4:       return BOX_W'(65535);
            default: return BOX_W'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic int pick_size();
        case ($urandom_range(0, 9))
            0:       return 1;
            1:       return 4096;
            2:       return SIZE_W'($urandom);
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    // Queue one detection of n class scores. Only the final request carries a
    // meaningful box, frame mark and tag; earlier ones carry noise there.
    task automatic add_detection(input int n, input logic [TAG_W-1:0] tag, input logic last_one);
        logic [SCORE_W-1:0] s;
        logic [SCORE_W-1:0] prev;
        prev = '0;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 19))
                0:       s = prev;                                   // tie with the last score
                1:       s = SCORE_W'(32768);                        // exactly 1.0
                2:       s = SCORE_W'($urandom_range(32769, 65535)); // above 1.0
                3:       s = SCORE_W'($urandom);
                4:       s = '0;
                default: s = SCORE_W'($urandom_range(0, 32768));
            endcase
            prev = s;
            if (i == n - 1)
                queue_req(s, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                          last_one, tag);
            else
                queue_req(s, BOX_W'($urandom), BOX_W'($urandom), BOX_W'($urandom),
                          BOX_W'($urandom), 1'($urandom), TAG_W'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Input driver: advance to the next request only once the current one is
    // taken (or nothing is up), so valid never follows in_stall. Work in
    // bursts, with a gap drawn at the end of each burst; long bursts come with
    // no gap at all.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || score_taken))
        begin
            score_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (score_requests.size() > 0)
            begin
                cur_req = score_requests.pop_front();
                class_score    <= cur_req.score;
                center_x       <= cur_req.cx;
                center_y       <= cur_req.cy;
                box_width      <= cur_req.bw;
                box_height     <= cur_req.bh;
                last_detection <= cur_req.last;
                frame_tag      <= cur_req.tag;
                in_valid       <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        burst_left = $urandom_range(20, 60);
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 8);
                        gap_left   = $urandom_range(1, 6);
                    end
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Input acceptance: a request moves when valid is high and stall is low.
    // Predict from the payload held on the port at that edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            score_taken = 1'b1;
            scores_taken++;
            absorb_score(cur_req);
        end
    end

    // ------------------------------------------------------------------------
    // Result stall: redraw the style periodically among no stall, light and
    // heavy random stall, and a fixed repeating on/off pattern.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        logic hold;
        if (rst_n)
        begin
            stall_tick++;
            if (stall_tick % 64 == 0)
                stall_style = $urandom_range(0, 3);
            case (stall_style)
                0:       hold = 1'b0;
                1:       hold = ($urandom_range(0, 3) == 0);
                2:       hold = ($urandom_range(0, 3) != 0);
                default: hold = (stall_tick % 16) < 9;
            endcase
            out_stall <= hold;
        end
    end

    // Result monitor: compare each taken result with the oldest prediction
    always @(posedge clk)
    begin
        box_result_t got;
        box_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.kept   = kept;
            got.cls    = best_class;
            got.conf   = confidence;
            got.left   = left_px;
            got.top    = top_px;
            got.right  = right_px;
            got.bottom = bottom_px;
            got.fend   = frame_end;
            got.tag    = result_tag;
            if (expected_boxes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: kept=%0b class=%0d conf=%0d tag=%0h",
                             got.kept, got.cls, got.conf, got.tag);
            end
            else
            begin
                want = expected_boxes.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                    begin
                        $display("result differs, expected kept=%0b class=%0d conf=%0d box=(%0d,%0d,%0d,%0d) end=%0b tag=%0h",
                                 want.kept, want.cls, want.conf, want.left, want.top,
                                 $signed(want.right), $signed(want.bottom), want.fend, want.tag);
                        $display("                 actual   kept=%0b class=%0d conf=%0d box=(%0d,%0d,%0d,%0d) end=%0b tag=%0h",
                                 got.kept, got.cls, got.conf, got.left, got.top,
                                 $signed(got.right), $signed(got.bottom), got.fend, got.tag);
                    end
                end
            end
        end
    end

    // Watchdog: end a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("detection_box_decode: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, power-up settings, directed corners, then random
    // phases. Every register change happens only after the block drains.
    // ------------------------------------------------------------------------
    initial
    begin
        int               eff;
        int               phase_items;
        int               dets;
        int               thr;
        int               cnt;
        logic [TAG_W-1:0] tag;

        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_THRESHOLD;
        cfg_data       = '0;
        in_valid       = 1'b0;
        class_score    = '0;
        center_x       = '0;
        center_y       = '0;
        box_width      = '0;
        box_height     = '0;
        last_detection = 1'b0;
        frame_tag      = '0;
        out_stall      = 1'b0;
        score_taken    = 1'b0;
        scores_queued  = 0;
        scores_taken   = 0;
        mismatches     = 0;
        cycle_count    = 0;
        burst_left     = 0;
        gap_left       = 0;
        stall_tick     = 0;
        stall_style    = 0;

        // Predicted power-up state
        score_thr = THRESHOLD_RST;
        img_w     = WIDTH_RST;
        img_h     = HEIGHT_RST;
        cls_count = COUNT_RST;
        run_best  = '0;
        run_class = '0;
        class_pos = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Power-up register values: one full detection at the reset class count
        add_detection(effective_count(cls_count), 8'h5A, 1'b1);
        wait_quiet();

        // --- Directed corners ---
        set_config(0, 4096, 4096, 3);
        // Tie on the running max: class 0 keeps the lead; box spans the image
        queue_req(100, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 1'b1, 8'hFF);
        queue_req(100, 17'h00000, 17'h00000, 17'h00000, 17'h00000, 1'b0, 8'h00);
        queue_req(50, 16384, 16384, 32768, 32768, 1'b0, 8'h01);
        // First class zero still seeds the max; a score above 1.0 wins but is dropped
        queue_req(0, 17'h0AAAA, 17'h15555, 17'h0AAAA, 17'h15555, 1'b1, 8'hAA);
        queue_req(32768, 17'h15555, 17'h0AAAA, 17'h15555, 17'h0AAAA, 1'b0, 8'h55);
        queue_req(32769, 100, 100, 100, 100, 1'b0, 8'h02);
        // Exactly 1.0 is kept; box pushed past both ends of the pixel fields
        queue_req(32768, 0, 0, 0, 0, 1'b0, 8'h03);
        queue_req(5, 0, 0, 0, 0, 1'b0, 8'h03);
        queue_req(32768, 65535, -65536, -65536, -65536, 1'b1, 8'hFF);
        wait_quiet();

        // Class count zero acts as one; score equal to the threshold is dropped
        set_config(1000, 1, 1, 0);
        queue_req(1000, 32768, 32768, 32768, 32768, 1'b0, 8'h10);
        queue_req(1001, 32768, 32768, 32768, 32768, 1'b0, 8'h10);
        queue_req(0, 32768, 32768, 32768, 32768, 1'b0, 8'h10);
        queue_req(65535, 32768, 32768, 32768, 32768, 1'b1, 8'h10);
        wait_quiet();

        // Zero image size: the upper clamp drops to minus one
        set_config(32767, 0, 0, 1);
        queue_req(32768, 16384, 16384, 16384, 16384, 1'b1, 8'h20);
        wait_quiet();

        // Class count lowered in the middle of a detection
        set_config(0, 640, 480, 4);
        queue_req(10, 0, 0, 0, 0, 1'b0, 8'h30);
        queue_req(20, 0, 0, 0, 0, 1'b0, 8'h30);
        queue_req(20, 0, 0, 0, 0, 1'b0, 8'h30);
        wait_quiet();
        set_config(0, 640, 480, 2);
        queue_req(32768, 20000, 10000, 8000, 6000, 1'b1, 8'h30);
        wait_quiet();

        // --- Random phases: frames of detections under changing settings ---
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: set_config(0, 1, 4096, 1);
                1: set_config(32767, 4096, 1, 128);
                2: set_config(32768, 8191, 0, 255);
                3: set_config(65535, 640, 480, 2);
                default:
                begin
                    case ($urandom_range(0, 9))
                        0:       thr = 0;
                        1:       thr = 32768;
                        2:       thr = SCORE_W'($urandom);
                        default: thr = $urandom_range(0, 32768);
                    endcase
                    case ($urandom_range(0, 9))
                        0:       cnt = 0;
                        1:       cnt = $urandom_range(100, 255);
                        2, 3, 4: cnt = $urandom_range(9, 40);
                        default: cnt = $urandom_range(1, 8);
                    endcase
                    set_config(thr, pick_size(), pick_size(), cnt);
                end
            endcase
            eff = effective_count(cls_count);
            phase_items = 0;
            while (phase_items < 70)
            begin
                tag  = TAG_W'($urandom);
                dets = (eff > 16) ? 1 : $urandom_range(1, 5);
                for (int d = 0; d < dets; d++)
                begin
                    add_detection(eff, tag, d == dets - 1);
                    phase_items += eff;
                end
            end
            // Leave a detection unfinished now and then; the next settings pick it up
            if (eff > 1 && $urandom_range(0, 1) == 1)
                add_detection($urandom_range(1, eff - 1), TAG_W'($urandom), 1'b0);
            wait_quiet();
        end

        if (mismatches == 0 && expected_boxes.size() == 0)
            $display("detection_box_decode: match");
        else
            $display("detection_box_decode: mismatch");
        $finish;
    end

endmodule
